>>> hdl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and constants for the round-trip latency monitor.
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int OUTSTANDING_DEF = 16;
  localparam int WINDOW_DEF      = 30;
  localparam logic [15:0] MAX_DELAY_RST = 16'd15000;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_ISSUE     = 3'd1,
    OP_REQ_IN    = 3'd2,
    OP_REPLY_IN  = 3'd3,
    OP_SWEEP     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_SEND_REQ   = 2'd0,
    KIND_SEND_REPLY = 2'd1,
    KIND_MEASURED   = 2'd2,
    KIND_TIMEOUT    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_POST,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_tag;
    logic        table_full;
    logic [15:0] elapsed_ms;
    logic [15:0] average_ms;
    logic        last;
  } out_item_t;

endpackage

>>> hdl/ping_latency_monitor.sv
// ----------------------------------------------------------------------------
// ping_latency_monitor
// Round-trip latency monitor with an outstanding table and a moving average.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------
//  in       | in_valid / in_ready   | in_data  (op, tag)
//  out      | out_valid / out_ready | out_data (result item)
//  cfg      | cfg_we                | cfg_data (max_delay_ms)
//
// a tick completes in idle; issue and incoming request go through flush. a reply
// or sweep scans the table one entry a cycle, pausing at each hit for a bit-serial
// divide for the new average and while a held result waits for out to be free.
// one result is held back so the final one can carry last.
// in_ready is low while an item is in progress; out stalls stretch it.
// rst is synchronous and clears the state, table valid bits, window and out_valid.
module ping_latency_monitor #(
  parameter int OUTSTANDING = plm_pkg::OUTSTANDING_DEF,
  parameter int WINDOW      = plm_pkg::WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  plm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output plm_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);
  import plm_pkg::*;

  localparam int IDXW = $clog2(OUTSTANDING);
  localparam int HW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNTW = $clog2(WINDOW + 1);
  localparam int SUMW = 16 + CNTW;
  localparam int DCW  = $clog2(SUMW + 1);
  localparam int OUTW = $bits(out_item_t);

  state_t state, state_next;

  logic [15:0] max_delay;
  logic [31:0] now_ms;
  logic [15:0] next_tag;
  logic [OUTSTANDING-1:0] entry_valid;
  logic [15:0] entry_tag   [OUTSTANDING];
  logic [31:0] entry_start [OUTSTANDING];
  logic [15:0] window_values [WINDOW];
  logic [HW-1:0]   window_head;
  logic [CNTW-1:0] window_count;
  logic [SUMW-1:0] window_sum;
  logic [15:0] average_delay;

  op_t         cur_op;
  logic [15:0] cur_tag;
  logic [IDXW-1:0] idx;
  logic [16:0] limit;

  logic [SUMW-1:0] div_num;
  logic [CNTW-1:0] div_rem;
  logic [CNTW-1:0] div_den;
  logic [DCW-1:0]  div_cnt;

  out_item_t   pend;
  logic        have_pend;
  logic [1:0]  res_kind;
  logic [15:0] res_tag;
  logic [15:0] res_elapsed;

  // free slot search
  logic            have_free;
  logic [IDXW-1:0] free_idx;
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = OUTSTANDING - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        have_free = 1'b1;
        free_idx  = IDXW'(i);
      end
    end
  end

  // entry under scan
  logic [31:0] age;
  logic [15:0] age_sat;
  logic        hit;
  logic        last_idx;
  always_comb begin
    age      = now_ms - entry_start[idx];
    age_sat  = (|age[31:16]) ? 16'hFFFF : age[15:0];
    last_idx = (idx == IDXW'(OUTSTANDING - 1));
    if (cur_op == OP_REPLY_IN) begin
      hit = entry_valid[idx] && (entry_tag[idx] == cur_tag);
    end else begin
      hit = entry_valid[idx] && (age >= {15'd0, limit});
    end
  end

  // window update for the value under scan
  logic            win_full;
  logic [SUMW-1:0] sum_next;
  logic [CNTW-1:0] count_next;
  logic [HW-1:0]   head_next;
  always_comb begin
    win_full   = (window_count == CNTW'(WINDOW));
    sum_next   = window_sum + SUMW'(age_sat)
                 - (win_full ? SUMW'(window_values[window_head]) : '0);
    count_next = win_full ? window_count : window_count + CNTW'(1);
    head_next  = (window_head == HW'(WINDOW - 1)) ? '0 : window_head + HW'(1);
  end

  // divider step
  logic [CNTW:0]   trial;
  logic            ge;
  logic [CNTW:0]   diff;
  always_comb begin
    trial = {div_rem, div_num[SUMW-1]};
    ge    = (trial >= {1'b0, div_den});
    diff  = trial - {1'b0, div_den};
  end

  logic        out_free;
  logic        out_load;
  logic [15:0] min_delay;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = have_pend && out_free && (state == ST_POST || state == ST_FLUSH);
  assign min_delay = (average_delay < max_delay) ? average_delay : max_delay;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.op)
            OP_ISSUE, OP_REQ_IN:    state_next = ST_FLUSH;
            OP_REPLY_IN, OP_SWEEP:  state_next = ST_SCAN;
            default:                state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_DIV;
        end else if (last_idx) begin
          state_next = ST_FLUSH;
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_POST;
        end
      end
      ST_POST: begin
        if (!have_pend || out_free) begin
          state_next = (cur_op == OP_REPLY_IN || last_idx) ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      max_delay     <= MAX_DELAY_RST;
      now_ms        <= '0;
      next_tag      <= '0;
      entry_valid   <= '0;
      window_head   <= '0;
      window_count  <= '0;
      window_sum    <= '0;
      average_delay <= '0;
      have_pend     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        max_delay <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_op  <= op_t'(in_data.op);
            cur_tag <= in_data.tag;
            idx     <= '0;
            limit   <= {min_delay, 1'b0};
            case (in_data.op)
              OP_TICK: now_ms <= now_ms + 32'd1;
              OP_ISSUE: begin
                next_tag <= next_tag + 16'd1;
                if (have_free) begin
                  entry_valid[free_idx] <= 1'b1;
                  entry_tag[free_idx]   <= next_tag;
                  entry_start[free_idx] <= now_ms;
                end
                pend      <= '{KIND_SEND_REQ, next_tag, !have_free, 16'd0,
                               average_delay, 1'b1};
                have_pend <= 1'b1;
              end
              OP_REQ_IN: begin
                pend      <= '{KIND_SEND_REPLY, in_data.tag, 1'b0, 16'd0,
                               average_delay, 1'b1};
                have_pend <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (hit) begin
            entry_valid[idx]           <= 1'b0;
            window_values[window_head] <= age_sat;
            window_sum   <= sum_next;
            window_count <= count_next;
            window_head  <= head_next;
            res_kind     <= (cur_op == OP_REPLY_IN) ? KIND_MEASURED : KIND_TIMEOUT;
            res_tag      <= entry_tag[idx];
            res_elapsed  <= age_sat;
            div_num      <= sum_next;
            div_rem      <= '0;
            div_den      <= count_next;
            div_cnt      <= DCW'(SUMW - 1);
          end else if (!last_idx) begin
            idx <= idx + IDXW'(1);
          end
        end
        ST_DIV: begin
          div_rem <= ge ? diff[CNTW-1:0] : trial[CNTW-1:0];
          div_num <= {div_num[SUMW-2:0], ge};
          div_cnt <= div_cnt - DCW'(1);
        end
        ST_POST: begin
          if (!have_pend || out_free) begin
            if (have_pend) begin
              out_data <= pend;
            end
            pend          <= '{res_kind, res_tag, 1'b0, res_elapsed,
                               div_num[15:0], 1'b0};
            have_pend     <= 1'b1;
            average_delay <= div_num[15:0];
            if (!last_idx) begin
              idx <= idx + IDXW'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            if (have_pend) begin
              // the final result of the item carries last
              out_data <= {pend[OUTW-1:1], 1'b1};
            end
            have_pend <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // a new item never finds a held-back result
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !have_pend)
    else $error("held result left over at idle");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |=> (state == ST_DIV || state == ST_POST))
    else $error("divide left early");

  assert property (@(posedge clk) disable iff (rst)
    window_count <= CNTW'(WINDOW))
    else $error("window count overflow");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == KIND_SEND_REQ || out_data.kind == KIND_SEND_REPLY)
    |-> out_data.last)
    else $error("send item without last");

endmodule
